FILE: src/kle_pkg.sv
// Shared types and constants for the keystroke line editor.
`timescale 1ns / 1ps
package kle_pkg;

    localparam int LINE_DEPTH = 63;
    localparam int ADDR_W     = 6;
    localparam int CNT_W      = 6;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [7:0]        t_char;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [8:0] key_code;
        logic       read_error;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_value;
        logic [5:0] erase_count;
        logic [5:0] line_length;
        logic       last;
    } t_out_item;

    // Result kinds.
    localparam logic [2:0] KIND_ECHO      = 3'd0;
    localparam logic [2:0] KIND_ERASE     = 3'd1;
    localparam logic [2:0] KIND_BEEP      = 3'd2;
    localparam logic [2:0] KIND_LINE_CHAR = 3'd3;
    localparam logic [2:0] KIND_DONE_OK   = 3'd4;
    localparam logic [2:0] KIND_DONE_ERR  = 3'd5;

    // Configuration register indexes.
    localparam logic REG_ECHO_ENABLE = 1'b0;
    localparam logic REG_MAX_LENGTH  = 1'b1;

    localparam logic       ECHO_RESET  = 1'b1;
    localparam t_cnt       MAXLEN_RESET = 6'd63;
    localparam t_cnt       MAX_LINE     = 6'd63;

    // Key codes.
    localparam logic [8:0] KEY_CTRL_H    = 9'd8;
    localparam logic [8:0] KEY_DEL       = 9'd127;
    localparam logic [8:0] KEY_ARROW_L   = 9'd260;
    localparam logic [8:0] KEY_BKSP      = 9'd263;
    localparam logic [8:0] KEY_DELCHAR   = 9'd330;
    localparam logic [8:0] KEY_CTRL_U    = 9'd21;
    localparam logic [8:0] KEY_CTRL_X    = 9'd24;
    localparam logic [8:0] KEY_DELLINE   = 9'd328;
    localparam logic [8:0] KEY_CTRL_W    = 9'd23;
    localparam logic [8:0] KEY_LF        = 9'd10;
    localparam logic [8:0] KEY_CR        = 9'd13;
    localparam logic [8:0] KEY_SUBMIT    = 9'd343;
    localparam logic [8:0] KEY_WINCH     = 9'd410;
    localparam logic [8:0] PRINT_LO      = 9'h020;
    localparam logic [8:0] PRINT_HI      = 9'h07E;
    localparam logic [8:0] HIGH_LO       = 9'h0A0;
    localparam logic [8:0] HIGH_HI       = 9'h0FF;
    localparam t_char      CHAR_SPACE    = 8'h20;

endpackage

FILE: src/kle_line_ram.sv
// Line store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module kle_line_ram
    import kle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_char i_wdata,
    input  t_addr i_raddr,
    output t_char o_rdata
);

    t_char r_mem [LINE_DEPTH];
    t_char r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/keystroke_line_editor_unit.sv
// Top level of the keystroke line editor: sequencer, line counters and result register.
// An edit key gives its result only while echo is on, a beep key always; word erase scans
// back one character at a time; Enter delivers each stored character and then a done item,
// all stretched by output stalls. One key is worked on at a time; the next is
// taken once the sequencer is back in idle.
// Reset clears the length, sequencer and result valid flag; echo on, limit 63, store left as is.
`timescale 1ns / 1ps
module keystroke_line_editor_unit
    import kle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [5:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WORD   = 3'd2;
    localparam logic [2:0] S_DLV    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] r_state, n_state;
    t_in_item   r_key;
    t_cnt       r_fill, n_fill;
    t_cnt       r_cnt, n_cnt;
    t_cnt       r_idx, n_idx;
    logic       r_phase, n_phase;
    logic       r_err_line, n_err_line;
    t_out_item  r_pend, n_pend;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;
    logic       r_echo;
    t_cnt       r_maxlen;

    logic       w_we;
    t_addr      w_raddr;
    t_char      w_rdata;
    logic       w_slot_free;
    logic [8:0] w_c;
    logic       w_is_erase, w_is_kill, w_is_word, w_is_print, w_is_enter;
    t_cnt       w_limit;
    t_out_item  w_blank;

    kle_line_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_fill),
        .i_wdata(r_key.key_code[7:0]),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign w_c        = r_key.key_code;
    assign w_is_erase = (w_c == KEY_CTRL_H) || (w_c == KEY_DEL) || (w_c == KEY_BKSP)
                        || (w_c == KEY_DELCHAR) || (w_c == KEY_ARROW_L);
    assign w_is_kill  = (w_c == KEY_CTRL_U) || (w_c == KEY_CTRL_X) || (w_c == KEY_DELLINE);
    assign w_is_word  = (w_c == KEY_CTRL_W);
    assign w_is_print = ((w_c >= PRINT_LO) && (w_c <= PRINT_HI))
                        || ((w_c >= HIGH_LO) && (w_c <= HIGH_HI));
    assign w_is_enter = (w_c == KEY_LF) || (w_c == KEY_CR) || (w_c == KEY_SUBMIT)
                        || (w_c == KEY_WINCH);
    assign w_limit    = (r_maxlen < MAX_LINE) ? r_maxlen : MAX_LINE;
    assign w_blank    = '0;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_err_line  = r_err_line;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_we        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_pend      = w_blank;
                n_pend.last = 1'b1;
                n_state     = S_EMIT;
                if (r_key.read_error || w_is_enter) begin
                    n_err_line = r_key.read_error;
                    n_idx      = '0;
                    n_state    = S_DLV;
                end else if (w_is_erase) begin
                    if (r_fill != '0) begin
                        n_fill = r_fill - 1'b1;
                        n_pend.kind        = KIND_ERASE;
                        n_pend.erase_count = 6'd1;
                        if (!r_echo) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_pend.kind = KIND_BEEP;
                    end
                end else if (w_is_kill) begin
                    n_fill             = '0;
                    n_pend.kind        = KIND_ERASE;
                    n_pend.erase_count = r_fill;
                    if (!r_echo || (r_fill == '0)) begin
                        n_state = S_IDLE;
                    end
                end else if (w_is_word) begin
                    n_cnt   = '0;
                    n_phase = 1'b0;
                    n_state = S_WORD;
                end else if (w_is_print) begin
                    if (r_fill < w_limit) begin
                        w_we              = 1'b1;
                        n_fill            = r_fill + 1'b1;
                        n_pend.kind       = KIND_ECHO;
                        n_pend.char_value = w_c[7:0];
                        if (!r_echo) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_pend.kind = KIND_BEEP;
                    end
                end else begin
                    n_pend.kind = KIND_BEEP;
                end
            end
            S_WORD: begin
                // The read data always holds the character just below the current end.
                if ((r_fill != '0) && (!r_phase || (w_rdata != CHAR_SPACE))) begin
                    n_fill = r_fill - 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    if (w_rdata != CHAR_SPACE) begin
                        n_phase = 1'b1;
                    end
                end else begin
                    n_pend             = w_blank;
                    n_pend.kind        = KIND_ERASE;
                    n_pend.erase_count = r_cnt;
                    n_pend.last        = 1'b1;
                    n_state = (r_echo && (r_cnt != '0)) ? S_EMIT : S_IDLE;
                end
            end
            S_DLV: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = w_blank;
                    if (r_idx < r_fill) begin
                        n_out.kind       = KIND_LINE_CHAR;
                        n_out.char_value = w_rdata;
                        n_idx            = r_idx + 1'b1;
                    end else begin
                        n_out.kind        = r_err_line ? KIND_DONE_ERR : KIND_DONE_OK;
                        n_out.line_length = r_fill;
                        n_out.last        = 1'b1;
                        n_fill            = '0;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_state == S_DLV) begin
            w_raddr = n_idx;
        end else if (n_fill != '0) begin
            w_raddr = n_fill - 1'b1;
        end else begin
            w_raddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_echo      <= ECHO_RESET;
            r_maxlen    <= MAXLEN_RESET;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ECHO_ENABLE: r_echo   <= i_cfg_data[0];
                    REG_MAX_LENGTH:  r_maxlen <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_key <= i_in_data;
        end
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_phase    <= n_phase;
        r_err_line <= n_err_line;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

endmodule
